@@ rtl/ppurt_pkg.sv @@
package ppurt_pkg;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    localparam logic [2:0] REG_CTRL    = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_OAMADDR = 3'd3;
    localparam logic [2:0] REG_OAMDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDR    = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    localparam logic [8:0] LAST_DOT     = 9'd340;
    localparam logic [8:0] LAST_LINE    = 9'd261;
    localparam logic [8:0] VBLANK_LINE  = 9'd241;
    localparam logic [8:0] VISIBLE_END  = 9'd240;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VREAD,
        ST_SEARCH,
        ST_SCAN,
        ST_OUT
    } state_t;

    function automatic logic [13:0] map_address(input logic [15:0] a_in);
        logic [13:0] a;
        a = a_in[13:0];
        if (a >= 14'h3000 && a < 14'h3F00)
            a = a - 14'h1000;
        else if (a >= 14'h3F00)
        begin
            a = {9'h1F8, a[4:0]};
            if (a[1:0] == 2'b00 && a[4])
                a[4] = 1'b0;
        end
        return a;
    endfunction

endpackage

@@ rtl/ppurt_vram.sv @@
module ppurt_vram (
    input  logic        clk,
    input  logic        we,
    input  logic [13:0] addr,
    input  logic [7:0]  wdata,
    output logic [7:0]  rdata
);
    logic [7:0] mem [16384];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

@@ rtl/ppurt_oam.sv @@
module ppurt_oam (
    input  logic       clk,
    input  logic       we,
    input  logic [7:0] waddr,
    input  logic [7:0] wdata,
    input  logic [7:0] raddr,
    output logic [7:0] rdata
);
    logic [7:0] mem [256];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/ppu_register_port_and_timing.sv @@
// channel | handshake                  | payload
// in      | in_valid / in_ready        | req_type, reg_select, write_data
// out     | out_valid / out_ready      | read_data, nmi_pulse, frame_ready,
//         |                            | line_sprite_count, sprite_overflow
// cfg     | cfg_we                     | cfg_data (mirroring_vertical)
// Each item is accepted, then its result goes into the output register.
// A data-register read also passes through the video memory read port first.
// A tick that starts a visible line scans object memory, one sprite a cycle,
// in ST_SEARCH and then ST_SCAN, through the object memory read port.
// One item is in flight at a time; a stalled output holds the block.
// Reset is asynchronous; the memories are not cleared.
module ppu_register_port_and_timing #(
    parameter int SPRITE_COUNT     = 64,
    parameter int SPRITES_PER_LINE = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [2:0] reg_select,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       nmi_pulse,
    output logic       frame_ready,
    output logic [3:0] line_sprite_count,
    output logic       sprite_overflow,
    input  logic       cfg_we,
    input  logic       cfg_data
);
    import ppurt_pkg::*;

    localparam int SW = $clog2(SPRITE_COUNT + 1);
    localparam int FW = $clog2(SPRITES_PER_LINE + 1);

    state_t state_reg, state_next;
    logic        mirror_reg;
    logic [15:0] vaddr_reg, vaddr_next;
    logic [7:0]  latch_reg, latch_next;
    logic        atog_reg, atog_next, stog_reg, stog_next;
    logic [7:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic [7:0]  rbuf_reg, rbuf_next;
    logic [7:0]  oaddr_reg, oaddr_next;
    logic [1:0]  ntb_reg, ntb_next;
    logic [4:0]  ctrl_reg, ctrl_next;
    logic [3:0]  mask_reg, mask_next;
    logic [2:0]  stat_reg, stat_next;
    logic [8:0]  dot_reg, dot_next, line_reg, line_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [FW-1:0] found_reg, found_next;
    logic [7:0]  list_reg [SPRITES_PER_LINE];
    logic        list_we;
    logic        clr_after_reg, clr_after_next;
    logic        ov_valid_reg, ov_valid_next;
    logic [7:0]  rd_reg, rd_next;
    logic        nmi_reg, nmi_next, frm_reg, frm_next;
    logic [3:0]  cnt_reg, cnt_next;

    logic        vram_we, oam_we;
    logic [13:0] vram_addr;
    logic [7:0]  vram_rdata, oam_rdata, oam_raddr;
    logic [8:0]  top, diff;
    logic [4:0]  height;
    logic        hit;
    logic [8:0]  line_inc;

    ppurt_vram u_vram (.clk(clk), .we(vram_we), .addr(vram_addr), .wdata(write_data),
                       .rdata(vram_rdata));
    ppurt_oam u_oam (.clk(clk), .we(oam_we), .waddr(oaddr_reg), .wdata(write_data),
                     .raddr(oam_raddr), .rdata(oam_rdata));

    assign vram_addr = map_address(vaddr_reg);
    assign oam_raddr = {6'(idx_reg), 2'b00};
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign read_data = rd_reg;
    assign nmi_pulse = nmi_reg;
    assign frame_ready = frm_reg;
    assign line_sprite_count = cnt_reg;
    assign sprite_overflow = ov_valid_reg & stat_reg[0];

    assign top    = {1'b0, oam_rdata} + 9'd1;
    assign diff   = line_reg - top;
    assign height = ctrl_reg[4] ? 5'd16 : 5'd8;
    assign hit    = (line_reg >= top) && (diff < {4'd0, height});
    assign line_inc = line_reg + 9'd1;

    always_comb
    begin
        state_next = state_reg;
        vaddr_next = vaddr_reg; latch_next = latch_reg; atog_next = atog_reg;
        stog_next = stog_reg; sx_next = sx_reg; sy_next = sy_reg;
        rbuf_next = rbuf_reg; oaddr_next = oaddr_reg; ntb_next = ntb_reg;
        ctrl_next = ctrl_reg; mask_next = mask_reg; stat_next = stat_reg;
        dot_next = dot_reg; line_next = line_reg; idx_next = idx_reg;
        found_next = found_reg; clr_after_next = clr_after_reg;
        ov_valid_next = ov_valid_reg;
        rd_next = rd_reg; nmi_next = nmi_reg; frm_next = frm_reg; cnt_next = cnt_reg;
        list_we = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rd_next = 8'd0; nmi_next = 1'b0; frm_next = 1'b0; cnt_next = 4'd0;
                    ov_valid_next = (req_type != REQ_NONE);
                    state_next = ST_OUT;
                end
            end
            ST_VREAD:
            begin
                state_next = ST_OUT;
                if (vram_addr >= 14'h3F00)
                begin
                    rd_next = vram_rdata; rbuf_next = vram_rdata;
                end
                else
                begin
                    rd_next = rbuf_reg; rbuf_next = vram_rdata;
                end
                vaddr_next = vaddr_reg + (ctrl_reg[1] ? 16'd32 : 16'd1);
            end
            ST_SEARCH:
            begin
                state_next = ST_SCAN;
                idx_next = idx_reg + SW'(1);
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    list_we = 1'b1;
                    found_next = found_reg + FW'(1);
                end
                if (hit && (found_reg + FW'(1) == FW'(SPRITES_PER_LINE)))
                begin
                    stat_next[0] = 1'b1;
                    state_next = ST_OUT;
                end
                else if (idx_reg == SW'(SPRITE_COUNT))
                    state_next = ST_OUT;
                else
                    idx_next = idx_reg + SW'(1);
                if (state_next == ST_OUT)
                begin
                    cnt_next = 4'((32'(found_next)));
                    if (clr_after_reg)
                        stat_next = 3'd0;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        if (state_reg == ST_IDLE && in_valid)
        begin
            case (req_type)
                REQ_TICK:
                begin
                    if (dot_reg >= LAST_DOT)
                    begin
                        dot_next = 9'd0;
                        line_next = line_inc;
                        clr_after_next = (line_inc == 9'd1);
                        if (line_inc < VISIBLE_END)
                        begin
                            idx_next = '0; found_next = '0;
                            state_next = ST_SEARCH;
                        end
                        if (line_inc > LAST_LINE)
                            line_next = 9'd0;
                        else if (line_inc == 9'd1)
                            stat_next = (line_inc < VISIBLE_END) ? stat_reg : 3'd0;
                        else if (line_inc == VBLANK_LINE)
                        begin
                            nmi_next = ctrl_reg[0];
                            stat_next[2] = 1'b1;
                            frm_next = 1'b1;
                        end
                    end
                    else
                        dot_next = dot_reg + 9'd1;
                end
                REQ_READ:
                begin
                    if (reg_select == REG_STATUS)
                    begin
                        rd_next = {stat_reg, 5'd0};
                        stat_next[2] = 1'b0;
                        atog_next = 1'b1; stog_next = 1'b1;
                    end
                    else if (reg_select == REG_DATA)
                        state_next = ST_VREAD;
                end
                REQ_WRITE:
                begin
                    case (reg_select)
                        REG_CTRL:
                        begin
                            ntb_next = write_data[1:0];
                            ctrl_next = {write_data[5], write_data[4], write_data[3],
                                         write_data[2], write_data[7]};
                        end
                        REG_MASK: mask_next = write_data[4:1];
                        REG_OAMADDR: oaddr_next = write_data;
                        REG_OAMDATA: oaddr_next = oaddr_reg + 8'd1;
                        REG_SCROLL:
                        begin
                            if (stog_reg) sx_next = write_data;
                            else sy_next = write_data;
                            stog_next = ~stog_reg;
                        end
                        REG_ADDR:
                        begin
                            if (atog_reg)
                                latch_next = write_data;
                            else
                            begin
                                if (mirror_reg && {latch_reg, write_data} >= 16'h2800)
                                    ntb_next = ({latch_reg, write_data} - 16'h0800
                                                > 16'h23FF) ? 2'd0 : 2'd1;
                                vaddr_next = {latch_reg, write_data};
                            end
                            atog_next = ~atog_reg;
                        end
                        REG_DATA: vaddr_next = vaddr_reg + (ctrl_reg[1] ? 16'd32 : 16'd1);
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        vram_we = 1'b0;
        oam_we = 1'b0;
        if (state_reg == ST_IDLE && in_valid && req_type == REQ_WRITE)
        begin
            vram_we = (reg_select == REG_DATA);
            oam_we  = (reg_select == REG_OAMDATA);
        end
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
            list_reg[found_reg[$clog2(SPRITES_PER_LINE > 1 ? SPRITES_PER_LINE : 2)-1:0]]
                <= oam_raddr - 8'd4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE; mirror_reg <= 1'b0; vaddr_reg <= '0; latch_reg <= '0;
            atog_reg <= 1'b1; stog_reg <= 1'b1; sx_reg <= '0; sy_reg <= '0;
            rbuf_reg <= '0; oaddr_reg <= '0; ntb_reg <= '0; ctrl_reg <= '0;
            mask_reg <= 4'hF; stat_reg <= '0; dot_reg <= '0; line_reg <= '0;
            idx_reg <= '0; found_reg <= '0; clr_after_reg <= 1'b0; ov_valid_reg <= 1'b0;
            rd_reg <= '0; nmi_reg <= 1'b0; frm_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                mirror_reg <= cfg_data;
            state_reg <= state_next; vaddr_reg <= vaddr_next; latch_reg <= latch_next;
            atog_reg <= atog_next; stog_reg <= stog_next; sx_reg <= sx_next;
            sy_reg <= sy_next; rbuf_reg <= rbuf_next; oaddr_reg <= oaddr_next;
            ntb_reg <= ntb_next; ctrl_reg <= ctrl_next; mask_reg <= mask_next;
            stat_reg <= stat_next; dot_reg <= dot_next; line_reg <= line_next;
            idx_reg <= idx_next; found_reg <= found_next; clr_after_reg <= clr_after_next;
            ov_valid_reg <= ov_valid_next; rd_reg <= rd_next; nmi_reg <= nmi_next;
            frm_reg <= frm_next; cnt_reg <= cnt_next;
        end
    end
endmodule

@@ bench/ppu_checker.sv @@
module ppu_checker
    import ppurt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [2:0] reg_select,
    input  logic [7:0] write_data,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] read_data,
    input  logic       nmi_pulse,
    input  logic       frame_ready,
    input  logic [3:0] line_sprite_count,
    input  logic       sprite_overflow,
    input  logic       cfg_we,
    input  logic       cfg_data,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [7:0] rd;
        logic       nmi;
        logic       frame;
        logic [3:0] cnt;
        logic       ovf;
    } bus_result_t;

    logic [7:0]  vram [16384];
    logic [7:0]  oam [256];
    logic [15:0] vaddr;
    logic [7:0]  addr_latch;
    logic        addr_high;
    logic [7:0]  rbuf;
    logic [7:0]  oaddr;
    logic [4:0]  ctrl;
    logic [2:0]  status;
    logic [8:0]  dot;
    logic [8:0]  line;
    logic        vertical;
    bus_result_t expected_results[$];

    function automatic logic [13:0] vram_index(input logic [15:0] a_in);
        int a;
        a = a_in & 16'h3FFF;
        if (a >= 'h3000 && a < 'h3F00)
            a = a - 'h1000;
        if (a >= 'h3F00)
        begin
            a = (a & 'h1F) + 'h3F00;
            if (a == 'h3F10 || a == 'h3F14 || a == 'h3F18 || a == 'h3F1C)
                a = a - 'h10;
        end
        return a[13:0];
    endfunction

    function automatic logic [3:0] count_sprites_on_line();
        int height;
        int found;
        int top;
        height = ctrl[4] ? 16 : 8;
        found = 0;
        for (int i = 0; i < 64; i++)
        begin
            top = int'(oam[i * 4]) + 1;
            if (int'(line) >= top && int'(line) - top < height)
            begin
                found++;
                if (found == 8)
                begin
                    status[0] = 1'b1;
                    break;
                end
            end
        end
        return found[3:0];
    endfunction

    task automatic predict_bus_item(input logic [1:0] rq, input logic [2:0] rs,
                                    input logic [7:0] d, output bus_result_t r);
        logic [13:0] a;
        r = '0;
        case (rq)
            REQ_TICK:
            begin
                if (dot >= LAST_DOT)
                begin
                    dot = '0;
                    line = line + 9'd1;
                    if (line < VISIBLE_END)
                        r.cnt = count_sprites_on_line();
                    if (line > LAST_LINE)
                        line = '0;
                    else if (line == 9'd1)
                        status = '0;
                    else if (line == VBLANK_LINE)
                    begin
                        r.nmi = ctrl[0];
                        status[2] = 1'b1;
                        r.frame = 1'b1;
                    end
                end
                else
                    dot = dot + 9'd1;
            end
            REQ_READ:
            begin
                if (rs == REG_STATUS)
                begin
                    r.rd = {status, 5'b0};
                    status[2] = 1'b0;
                    addr_high = 1'b1;
                end
                else if (rs == REG_DATA)
                begin
                    a = vram_index(vaddr);
                    if (a >= 14'h3F00)
                    begin
                        r.rd = vram[a];
                        rbuf = vram[a];
                    end
                    else
                    begin
                        r.rd = rbuf;
                        rbuf = vram[a];
                    end
                    vaddr = vaddr + (ctrl[1] ? 16'd32 : 16'd1);
                end
            end
            REQ_WRITE:
            begin
                case (rs)
                    REG_CTRL:    ctrl = {d[5], d[4], d[3], d[2], d[7]};
                    REG_OAMADDR: oaddr = d;
                    REG_OAMDATA:
                    begin
                        oam[oaddr] = d;
                        oaddr = oaddr + 8'd1;
                    end
                    REG_ADDR:
                    begin
                        if (addr_high)
                            addr_latch = d;
                        else
                            vaddr = {addr_latch, d};
                        addr_high = !addr_high;
                    end
                    REG_DATA:
                    begin
                        vram[vram_index(vaddr)] = d;
                        vaddr = vaddr + (ctrl[1] ? 16'd32 : 16'd1);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.ovf = (rq == REQ_NONE) ? 1'b0 : status[0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bus_result_t r;
        bus_result_t e;
        if (!rst_n)
        begin
            vaddr = '0;
            addr_latch = '0;
            addr_high = 1'b1;
            rbuf = '0;
            oaddr = '0;
            ctrl = '0;
            status = '0;
            dot = '0;
            line = '0;
            vertical = 1'b0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
                vertical = cfg_data;
            if (in_valid && in_ready)
            begin
                predict_bus_item(req_type, reg_select, write_data, r);
                expected_results.push_back(r);
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (read_data !== e.rd)
                    begin
                        $error("read_data expected %0h got %0h", e.rd, read_data);
                        fail_count++;
                    end
                    if (nmi_pulse !== e.nmi)
                    begin
                        $error("nmi_pulse expected %0h got %0h", e.nmi, nmi_pulse);
                        fail_count++;
                    end
                    if (frame_ready !== e.frame)
                    begin
                        $error("frame_ready expected %0h got %0h", e.frame, frame_ready);
                        fail_count++;
                    end
                    if (line_sprite_count !== e.cnt)
                    begin
                        $error("line_sprite_count expected %0h got %0h", e.cnt,
                               line_sprite_count);
                        fail_count++;
                    end
                    if (sprite_overflow !== e.ovf)
                    begin
                        $error("sprite_overflow expected %0h got %0h", e.ovf,
                               sprite_overflow);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

@@ bench/tb.sv @@
module tb;
    import ppurt_pkg::*;

    localparam int STALL_LIMIT = 3000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] req_type = REQ_TICK;
    logic [2:0] reg_select = REG_CTRL;
    logic [7:0] write_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;
    logic       nmi_pulse;
    logic       frame_ready;
    logic [3:0] line_sprite_count;
    logic       sprite_overflow;
    logic       cfg_we = 1'b0;
    logic       cfg_data = 1'b0;
    int         fail_count;
    int         pending;
    int         quiet_cycles = 0;
    bit         send_gaps = 1'b0;
    bit         sink_stalls = 1'b0;
    bit         hold_sink = 1'b0;

    ppu_register_port_and_timing dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .reg_select(reg_select), .write_data(write_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .read_data(read_data), .nmi_pulse(nmi_pulse), .frame_ready(frame_ready),
        .line_sprite_count(line_sprite_count), .sprite_overflow(sprite_overflow),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    ppu_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .reg_select(reg_select), .write_data(write_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .read_data(read_data), .nmi_pulse(nmi_pulse), .frame_ready(frame_ready),
        .line_sprite_count(line_sprite_count), .sprite_overflow(sprite_overflow),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** ppu_register_port_and_timing: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_sink)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_sink = 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 11);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_item(input req_t rq, input logic [2:0] rs, input logic [7:0] d);
        int n;
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        reg_select <= rs;
        write_data <= d;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_mirroring(input logic v);
        settle();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // point the address at a filled byte, then read it
    task automatic read_window();
        int pick;
        logic [7:0] hi;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            hi = 8'h20;
        else if (pick == 1)
            hi = 8'h30;
        else if (pick == 2)
            hi = 8'h3F;
        else
            hi = 8'h7F;
        send_item(REQ_READ, REG_STATUS, 8'($urandom));
        send_item(REQ_WRITE, REG_ADDR, hi);
        send_item(REQ_WRITE, REG_ADDR,
                  (pick < 2) ? 8'($urandom_range(0, 63)) : 8'($urandom));
        send_item(REQ_READ, REG_DATA, 8'($urandom));
    endtask

    task automatic random_item();
        int pick;
        logic [2:0] rs;
        pick = $urandom_range(0, 99);
        rs = 3'($urandom_range(0, 7));
        if (pick < 50)
            send_item(REQ_TICK, rs, 8'($urandom));
        else if (pick < 72)
        begin
            if (rs == REG_DATA)
                read_window();
            else
                send_item(REQ_READ, rs, 8'($urandom));
        end
        else if (pick < 95)
            send_item(REQ_WRITE, rs, 8'($urandom));
        else
            send_item(REQ_NONE, rs, 8'($urandom));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mirroring(1'b0);

        // fill object memory, sprite Y values crowded near the top
        send_item(REQ_WRITE, REG_OAMADDR, 8'h00);
        for (int i = 0; i < 256; i++)
            send_item(REQ_WRITE, REG_OAMDATA,
                      (i % 4 == 0) ? 8'($urandom_range(0, 4)) : 8'($urandom));
        // fill a window of name table and the palette
        send_item(REQ_WRITE, REG_ADDR, 8'h20);
        send_item(REQ_WRITE, REG_ADDR, 8'h00);
        for (int i = 0; i < 64; i++)
            send_item(REQ_WRITE, REG_DATA, 8'($urandom));
        send_item(REQ_WRITE, REG_ADDR, 8'h3F);
        send_item(REQ_WRITE, REG_ADDR, 8'h00);
        for (int i = 0; i < 32; i++)
            send_item(REQ_WRITE, REG_DATA, 8'($urandom));

        send_item(REQ_READ, REG_STATUS, 8'h00);
        send_item(REQ_READ, REG_DATA, 8'hFF);
        send_item(REQ_WRITE, REG_ADDR, 8'h20);
        send_item(REQ_WRITE, REG_ADDR, 8'h08);
        send_item(REQ_READ, REG_DATA, 8'h00);
        send_item(REQ_READ, REG_DATA, 8'h00);
        for (int r = 0; r < 8; r++)
            send_item(REQ_READ, 3'(r), 8'h00);
        send_item(REQ_WRITE, REG_STATUS, 8'hFF);
        send_item(REQ_WRITE, REG_MASK, 8'hFF);
        send_item(REQ_WRITE, REG_SCROLL, 8'h00);
        send_item(REQ_WRITE, REG_SCROLL, 8'hFF);
        send_item(REQ_WRITE, REG_CTRL, 8'hFF);
        send_item(REQ_WRITE, REG_DATA, 8'h5A);
        send_item(REQ_READ, REG_DATA, 8'h00);
        send_item(REQ_NONE, REG_DATA, 8'hFF);
        send_item(REQ_TICK, REG_CTRL, 8'h00);

        set_mirroring(1'b1);
        send_item(REQ_WRITE, REG_ADDR, 8'h2C);
        send_item(REQ_WRITE, REG_ADDR, 8'h10);
        send_item(REQ_WRITE, REG_ADDR, 8'h28);
        send_item(REQ_WRITE, REG_ADDR, 8'h00);
        send_item(REQ_WRITE, REG_ADDR, 8'h3F);
        send_item(REQ_WRITE, REG_ADDR, 8'hFF);
        send_item(REQ_READ, REG_DATA, 8'h00);
        send_item(REQ_WRITE, REG_CTRL, 8'h80);
        // run the first lines: sprite search and overflow
        for (int i = 0; i < 341 * 2; i++)
            send_item(REQ_TICK, 3'($urandom_range(0, 7)), 8'($urandom));
        send_item(REQ_WRITE, REG_CTRL, 8'hA0);
        for (int i = 0; i < 341; i++)
            send_item(REQ_TICK, REG_CTRL, 8'h00);

        send_gaps = 1'b1;
        sink_stalls = 1'b1;
        for (int chunk = 0; chunk < 7; chunk++)
        begin
            if (chunk == 6)
            begin
                send_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            set_mirroring(chunk[0]);
            if (chunk == 2)
                hold_sink = 1'b1;
            for (int i = 0; i < 45; i++)
                random_item();
            if (chunk == 4)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** ppu_register_port_and_timing: PASSED **");
        else
            $display("** ppu_register_port_and_timing: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ppurt_pkg.sv
rtl/ppurt_vram.sv
rtl/ppurt_oam.sv
rtl/ppu_register_port_and_timing.sv
bench/ppu_checker.sv
bench/tb.sv
